@@ design/lcs_pkg.sv @@
// Shared types, character constants and helpers for the layout and comment skipper.
// Depends on nothing; every other design file refers to it by scoped names.
package lcs_pkg;

  // Characters that the scanner recognises.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  // Configuration register indexes.
  localparam logic REG_LINE_COMMENTS = 1'b0;
  localparam logic REG_NESTING       = 1'b1;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_NORMAL      = 3'd0,
    MODE_SLASH       = 3'd1,
    MODE_LINE        = 3'd2,
    MODE_BLOCK       = 3'd3,
    MODE_BLOCK_STAR  = 3'd4,
    MODE_BLOCK_SLASH = 3'd5
  } scan_mode_t;

  // Configuration as seen by the scanner.
  typedef struct packed {
    logic line_on;
    logic nest_on;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] kept_byte;
    logic       kept_valid;
    logic       last_of_text;
    logic       open_comment;
    logic       depth_overflow;
  } result_t;

  // True for space, tab and newline.
  function automatic logic is_layout(input logic [7:0] b);
    is_layout = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
  endfunction

  // A kept byte with the flags still clear.
  function automatic result_t kept(input logic [7:0] b);
    result_t r;
    r = '0;
    r.kept_byte  = b;
    r.kept_valid = 1'b1;
    kept = r;
  endfunction

endpackage

@@ design/lcs_cfg.sv @@
// APB-style register file for the two enable bits of the skipper.
// Depends on lcs_pkg for the register indexes and the cfg_t type.
module lcs_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lcs_pkg::cfg_t      cfg
);

  logic line_on;
  logic nest_on;
  logic wr_en;
  logic idx;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_on <= 1'b1;
      nest_on <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        lcs_pkg::REG_LINE_COMMENTS: line_on <= pwdata[0];
        lcs_pkg::REG_NESTING:       nest_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    prdata = '0;
    unique case (idx)
      lcs_pkg::REG_LINE_COMMENTS: prdata[0] = line_on;
      lcs_pkg::REG_NESTING:       prdata[0] = nest_on;
      default: prdata = '0;
    endcase
  end

  assign cfg.line_on = line_on;
  assign cfg.nest_on = nest_on;

endmodule

@@ design/lcs_scan.sv @@
// Scanner state registers and the per-item next-state and result logic.
// Depends on lcs_pkg for modes, character constants and the result type.
module lcs_scan #(
  parameter int MAX_NEST = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  lcs_pkg::cfg_t      cfg,
  input  logic               accept,
  input  logic [7:0]         text_byte,
  input  logic               byte_present,
  input  logic               text_end,
  output logic [1:0]         res_count,
  output lcs_pkg::result_t   res0,
  output lcs_pkg::result_t   res1
);

  localparam int DW = $clog2(MAX_NEST + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST);
  localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

  lcs_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic [DW-1:0]       nest_depth, nest_depth_next;
  logic                overflow_seen, overflow_seen_next;

  lcs_pkg::scan_mode_t m;
  logic [DW-1:0]       d;
  logic                o;
  logic [1:0]          n;
  logic                open;
  lcs_pkg::result_t    r0, r1;

  // State registers, updated only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= lcs_pkg::MODE_NORMAL;
      nest_depth    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      nest_depth    <= nest_depth_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Byte handling followed by end-of-text handling.
  always_comb begin
    m    = scan_mode;
    d    = nest_depth;
    o    = overflow_seen;
    n    = 2'd0;
    r0   = '0;
    r1   = '0;
    open = 1'b0;

    if (byte_present) begin
      unique case (m)
        lcs_pkg::MODE_SLASH: begin
          if (text_byte == lcs_pkg::CH_SLASH && cfg.line_on) begin
            m = lcs_pkg::MODE_LINE;
          end else if (text_byte == lcs_pkg::CH_STAR) begin
            m = lcs_pkg::MODE_BLOCK;
            d = DEPTH_ONE;
          end else begin
            // The held slash goes out first, then the byte as plain text.
            r0 = lcs_pkg::kept(lcs_pkg::CH_SLASH);
            n  = 2'd1;
            if (lcs_pkg::is_layout(text_byte)) begin
              m = lcs_pkg::MODE_NORMAL;
            end else if (text_byte == lcs_pkg::CH_SLASH) begin
              m = lcs_pkg::MODE_SLASH;
            end else begin
              m  = lcs_pkg::MODE_NORMAL;
              r1 = lcs_pkg::kept(text_byte);
              n  = 2'd2;
            end
          end
        end
        lcs_pkg::MODE_LINE: begin
          if (text_byte == lcs_pkg::CH_NL) m = lcs_pkg::MODE_NORMAL;
        end
        lcs_pkg::MODE_BLOCK: begin
          if (text_byte == lcs_pkg::CH_STAR) begin
            m = lcs_pkg::MODE_BLOCK_STAR;
          end else if (text_byte == lcs_pkg::CH_SLASH && cfg.nest_on) begin
            m = lcs_pkg::MODE_BLOCK_SLASH;
          end
        end
        lcs_pkg::MODE_BLOCK_STAR: begin
          if (text_byte == lcs_pkg::CH_SLASH) begin
            if (d != '0) d = d - DEPTH_ONE;
            if (d == '0 || !cfg.nest_on) begin
              d = '0;
              m = lcs_pkg::MODE_NORMAL;
            end else begin
              m = lcs_pkg::MODE_BLOCK;
            end
          end else if (text_byte != lcs_pkg::CH_STAR) begin
            m = lcs_pkg::MODE_BLOCK;
          end
        end
        lcs_pkg::MODE_BLOCK_SLASH: begin
          if (text_byte == lcs_pkg::CH_STAR) begin
            // Saturate the depth and remember that it happened.
            if (d >= DEPTH_MAX) begin
              d = DEPTH_MAX;
              o = 1'b1;
            end else begin
              d = d + DEPTH_ONE;
            end
            m = lcs_pkg::MODE_BLOCK;
          end else if (text_byte != lcs_pkg::CH_SLASH) begin
            m = lcs_pkg::MODE_BLOCK;
          end
        end
        default: begin
          // Normal text.
          if (lcs_pkg::is_layout(text_byte)) begin
            m = lcs_pkg::MODE_NORMAL;
          end else if (text_byte == lcs_pkg::CH_SLASH) begin
            m = lcs_pkg::MODE_SLASH;
          end else begin
            m  = lcs_pkg::MODE_NORMAL;
            r0 = lcs_pkg::kept(text_byte);
            n  = 2'd1;
          end
        end
      endcase
    end

    if (text_end) begin
      open = (m == lcs_pkg::MODE_BLOCK) || (m == lcs_pkg::MODE_BLOCK_STAR) ||
             (m == lcs_pkg::MODE_BLOCK_SLASH);
      // Flush a held slash.
      if (m == lcs_pkg::MODE_SLASH) begin
        if (n == 2'd0) r0 = lcs_pkg::kept(lcs_pkg::CH_SLASH);
        else           r1 = lcs_pkg::kept(lcs_pkg::CH_SLASH);
        n = n + 2'd1;
      end
      // An empty marker item when nothing else goes out.
      if (n == 2'd0) begin
        r0 = '0;
        n  = 2'd1;
      end
      if (n == 2'd1) begin
        r0.last_of_text = 1'b1;
        r0.open_comment = open;
      end else begin
        r1.last_of_text = 1'b1;
        r1.open_comment = open;
      end
    end

    r0.depth_overflow = o;
    r1.depth_overflow = o;

    res_count = n;
    res0      = r0;
    res1      = r1;

    if (text_end) begin
      scan_mode_next     = lcs_pkg::MODE_NORMAL;
      nest_depth_next    = '0;
      overflow_seen_next = 1'b0;
    end else begin
      scan_mode_next     = m;
      nest_depth_next    = d;
      overflow_seen_next = o;
    end
  end

`ifndef NO_ASSERTIONS
  // Outside a block comment the depth is always zero.
  a_depth_zero_outside: assert property (@(posedge clk) disable iff (rst)
    (scan_mode == lcs_pkg::MODE_NORMAL || scan_mode == lcs_pkg::MODE_SLASH ||
     scan_mode == lcs_pkg::MODE_LINE) |-> nest_depth == '0)
    else $error("nest depth non-zero outside a block comment");

  // Inside a block comment at least one level is open.
  a_depth_set_inside: assert property (@(posedge clk) disable iff (rst)
    (scan_mode == lcs_pkg::MODE_BLOCK || scan_mode == lcs_pkg::MODE_BLOCK_STAR ||
     scan_mode == lcs_pkg::MODE_BLOCK_SLASH) |-> nest_depth != '0)
    else $error("block comment with zero depth");

  // End of text returns the scanner to idle.
  a_end_idles: assert property (@(posedge clk) disable iff (rst)
    accept && text_end |=> scan_mode == lcs_pkg::MODE_NORMAL &&
                           nest_depth == '0 && !overflow_seen)
    else $error("scanner not idle after end of text");

  // An end-of-text item always yields at least one result.
  a_end_has_result: assert property (@(posedge clk) disable iff (rst)
    text_end |-> res_count != 2'd0)
    else $error("end of text without a result");
`endif

endmodule

@@ design/lcs_outq.sv @@
// 4-entry result queue: up to two in a cycle, one out a cycle while out_ready.
// Depends on lcs_pkg for the result_t type.
module lcs_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_count,
  input  lcs_pkg::result_t   push0,
  input  lcs_pkg::result_t   push1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output lcs_pkg::result_t   head
);

  lcs_pkg::result_t entries [4];
  logic [1:0] wr_ptr, wr_ptr_next;
  logic [1:0] rd_ptr, rd_ptr_next;
  logic [2:0] count, count_next;
  logic       pop;
  logic [1:0] wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign room      = count <= 3'd2;
  assign head      = entries[rd_ptr];
  assign wr_ptr_p1 = wr_ptr + 2'd1;

  always_comb begin
    wr_ptr_next = wr_ptr + push_count;
    rd_ptr_next = rd_ptr + {1'b0, pop};
    count_next  = count + {1'b0, push_count} - {2'b0, pop};
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Entry storage: the first result at the write pointer, the second after it.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (push_count != 2'd0 && wr_ptr == 2'(i)) begin
        entries[i] <= push0;
      end else if (push_count == 2'd2 && wr_ptr_p1 == 2'(i)) begin
        entries[i] <= push1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The queue never overfills.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overfilled");

  // Items only arrive while there is room for two.
  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> room)
    else $error("results pushed without room");

  // Fill level tracks pushes and pops.
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + {1'b0, $past(push_count)} - {2'b0, $past(pop)})
    else $error("fill level out of step");
`endif

endmodule

@@ design/layout_and_comment_skipper.sv @@
// Top level of the layout and comment skipper: register file, scanner, result queue.
// Depends on lcs_pkg, lcs_cfg, lcs_scan and lcs_outq.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    text_byte, byte_present, text_end
//  output    out_valid / out_ready  kept_byte, kept_valid, last_of_text,
//                                   open_comment, depth_overflow
//  config    psel / penable         pwrite, paddr, pwdata, prdata (pready high)
//
// One item is accepted per cycle while the result queue has room for two results;
// its results enter the result queue. An item that releases a held slash can make
// two results; the single output port drains one per cycle while out_ready is high,
// which briefly holds off input. A stalled output holds off input once three results
// are waiting. Reset is synchronous and returns the scanner to normal text.
module layout_and_comment_skipper #(
  parameter int MAX_NEST = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        byte_present,
  input  logic        text_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  kept_byte,
  output logic        kept_valid,
  output logic        last_of_text,
  output logic        open_comment,
  output logic        depth_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lcs_pkg::cfg_t    cfg;
  lcs_pkg::result_t res0, res1, head;
  logic [1:0]       res_count;
  logic [1:0]       push_count;
  logic             accept;
  logic             room;

  assign in_ready   = room;
  assign accept     = in_valid && in_ready;
  assign push_count = accept ? res_count : 2'd0;

  lcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcs_scan #(
    .MAX_NEST (MAX_NEST)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .text_end     (text_end),
    .res_count    (res_count),
    .res0         (res0),
    .res1         (res1)
  );

  lcs_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head)
  );

  assign kept_byte      = head.kept_byte;
  assign kept_valid     = head.kept_valid;
  assign last_of_text   = head.last_of_text;
  assign open_comment   = head.open_comment;
  assign depth_overflow = head.depth_overflow;

endmodule

@@ tb/stripped_text_monitor.sv @@
// Monitor for the layout and comment skipper: predicts the kept bytes and end flags.
// Depends on lcs_pkg for the result layout, scanner modes and character codes.
module stripped_text_monitor #(
  parameter int MAX_NEST = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        byte_present,
  input  logic        text_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  kept_byte,
  input  logic        kept_valid,
  input  logic        last_of_text,
  input  logic        open_comment,
  input  logic        depth_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  // Scanner state and register copies kept in step with the block.
  lcs_pkg::scan_mode_t mode;
  int                  depth;
  logic                overflow_seen;
  logic                line_on;
  logic                nest_on;

  lcs_pkg::result_t expected_kept[$];
  lcs_pkg::result_t step_results[$];

  // A byte that survives stripping, tagged with the current overflow flag.
  task automatic emit_byte(input logic [7:0] b);
    lcs_pkg::result_t r;
    r = '0;
    r.kept_byte      = b;
    r.kept_valid     = 1'b1;
    r.depth_overflow = overflow_seen;
    step_results.push_back(r);
  endtask

  // Ordinary text: layout is dropped, a slash is held back, anything else is kept.
  task automatic scan_plain(input logic [7:0] b);
    if (b == lcs_pkg::CH_SPACE || b == lcs_pkg::CH_TAB || b == lcs_pkg::CH_NL) begin
      mode = lcs_pkg::MODE_NORMAL;
    end else if (b == lcs_pkg::CH_SLASH) begin
      mode = lcs_pkg::MODE_SLASH;
    end else begin
      mode = lcs_pkg::MODE_NORMAL;
      emit_byte(b);
    end
  endtask

  // One byte through the comment state machine.
  task automatic scan_byte(input logic [7:0] b);
    case (mode)
      lcs_pkg::MODE_SLASH: begin
        if (b == lcs_pkg::CH_SLASH && line_on) begin
          mode = lcs_pkg::MODE_LINE;
        end else if (b == lcs_pkg::CH_STAR) begin
          mode  = lcs_pkg::MODE_BLOCK;
          depth = 1;
        end else begin
          emit_byte(lcs_pkg::CH_SLASH);
          scan_plain(b);
        end
      end
      lcs_pkg::MODE_LINE: begin
        if (b == lcs_pkg::CH_NL) mode = lcs_pkg::MODE_NORMAL;
      end
      lcs_pkg::MODE_BLOCK: begin
        if (b == lcs_pkg::CH_STAR) mode = lcs_pkg::MODE_BLOCK_STAR;
        else if (b == lcs_pkg::CH_SLASH && nest_on) mode = lcs_pkg::MODE_BLOCK_SLASH;
      end
      lcs_pkg::MODE_BLOCK_STAR: begin
        if (b == lcs_pkg::CH_SLASH) begin
          if (depth > 0) depth = depth - 1;
          if (depth == 0 || !nest_on) begin
            depth = 0;
            mode  = lcs_pkg::MODE_NORMAL;
          end else begin
            mode = lcs_pkg::MODE_BLOCK;
          end
        end else if (b != lcs_pkg::CH_STAR) begin
          mode = lcs_pkg::MODE_BLOCK;
        end
      end
      lcs_pkg::MODE_BLOCK_SLASH: begin
        if (b == lcs_pkg::CH_STAR) begin
          // Opening beyond the limit saturates the depth and raises the flag.
          if (depth >= MAX_NEST) begin
            depth         = MAX_NEST;
            overflow_seen = 1'b1;
          end else begin
            depth = depth + 1;
          end
          mode = lcs_pkg::MODE_BLOCK;
        end else if (b != lcs_pkg::CH_SLASH) begin
          mode = lcs_pkg::MODE_BLOCK;
        end
      end
      default: scan_plain(b);
    endcase
  endtask

  // Works out every result of one accepted item and queues them in order.
  task automatic strip_item(input logic [7:0] b, input logic present, input logic ends);
    lcs_pkg::result_t r;
    logic             was_open;
    step_results.delete();
    if (present) scan_byte(b);
    if (ends) begin
      was_open = (mode == lcs_pkg::MODE_BLOCK) || (mode == lcs_pkg::MODE_BLOCK_STAR) ||
                 (mode == lcs_pkg::MODE_BLOCK_SLASH);
      if (mode == lcs_pkg::MODE_SLASH) emit_byte(lcs_pkg::CH_SLASH);
      if (step_results.size() == 0) begin
        r = '0;
        step_results.push_back(r);
      end
      // The final result of the text carries the end flags.
      r = step_results.pop_back();
      r.last_of_text   = 1'b1;
      r.open_comment   = was_open;
      r.depth_overflow = overflow_seen;
      step_results.push_back(r);
      mode          = lcs_pkg::MODE_NORMAL;
      depth         = 0;
      overflow_seen = 1'b0;
    end
    foreach (step_results[i]) expected_kept.push_back(step_results[i]);
  endtask

  // Compares one delivered result with the oldest one predicted.
  task automatic compare_result(input lcs_pkg::result_t got);
    lcs_pkg::result_t want;
    if (expected_kept.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result byte %02h valid %b last %b open %b ovf %b",
                 $time, got.kept_byte, got.kept_valid, got.last_of_text,
                 got.open_comment, got.depth_overflow);
    end else begin
      want = expected_kept.pop_front();
      checked++;
      if (want.kept_byte != got.kept_byte || want.kept_valid != got.kept_valid ||
          want.last_of_text != got.last_of_text ||
          want.open_comment != got.open_comment ||
          want.depth_overflow != got.depth_overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch, expected %02h/%b/%b/%b/%b, got %02h/%b/%b/%b/%b",
                   $time, want.kept_byte, want.kept_valid, want.last_of_text,
                   want.open_comment, want.depth_overflow, got.kept_byte,
                   got.kept_valid, got.last_of_text, got.open_comment,
                   got.depth_overflow);
      end
    end
  endtask

  // Results are checked before the item of the same edge is predicted, since
  // a result never leaves in the cycle its item is taken.
  always @(posedge clk) begin
    lcs_pkg::result_t got;
    if (rst) begin
      line_on       = 1'b1;
      nest_on       = 1'b1;
      mode          = lcs_pkg::MODE_NORMAL;
      depth         = 0;
      overflow_seen = 1'b0;
      expected_kept.delete();
      mismatches    = 0;
      checked       = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {kept_byte, kept_valid, last_of_text, open_comment, depth_overflow};
        compare_result(got);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == lcs_pkg::REG_NESTING) nest_on = pwdata[0];
        else line_on = pwdata[0];
      end
      if (in_valid && in_ready) strip_item(text_byte, byte_present, text_end);
    end
    pending = expected_kept.size();
  end

endmodule

@@ tb/layout_and_comment_skipper_tb.sv @@
// Testbench top for the layout and comment skipper: clock, reset, text and register stimulus.
// Depends on lcs_pkg, the design and stripped_text_monitor, which does all the checking.
module layout_and_comment_skipper_tb;

  localparam int MAX_NEST = 15;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        byte_present = 1'b0;
  logic        text_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [7:0]  kept_byte;
  logic        kept_valid;
  logic        last_of_text;
  logic        open_comment;
  logic        depth_overflow;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int checked;

  // Idling controls; a calm stretch means no gaps on that side.
  logic calm = 1'b0;
  logic sink_calm = 1'b0;
  int   stall_left = 0;
  int   items_sent = 0;
  logic [7:0] snippet[$];

  always #2 clk = ~clk;

  layout_and_comment_skipper #(
    .MAX_NEST(MAX_NEST)
  ) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .byte_present(byte_present), .text_end(text_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept_byte(kept_byte), .kept_valid(kept_valid), .last_of_text(last_of_text),
    .open_comment(open_comment), .depth_overflow(depth_overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stripped_text_monitor #(
    .MAX_NEST(MAX_NEST)
  ) u_monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .byte_present(byte_present), .text_end(text_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept_byte(kept_byte), .kept_valid(kept_valid), .last_of_text(last_of_text),
    .open_comment(open_comment), .depth_overflow(depth_overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  // Receiver stalls: mostly short, now and then a long one.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!sink_calm && $urandom_range(0, 99) < 20) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sender gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Presents one item and holds it until it is taken. Called and returns at a
  // falling edge; valid stays high when the next item follows without a gap.
  task automatic send_item(input logic [7:0] b, input logic present, input logic ends);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    text_byte    <= b;
    byte_present <= present;
    text_end     <= ends;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (present || ends) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic end_on_last);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, end_on_last && (i == s.len() - 1));
  endtask

  // Stops sending until every predicted result has been delivered and the
  // pipeline has had time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Comment body text: mostly letters, some layout, stars and slashes.
  task automatic push_filler(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r < 12) snippet.push_back(8'(8'h61 + $urandom_range(0, 25)));
      else if (r < 14) snippet.push_back(lcs_pkg::CH_SPACE);
      else if (r < 15) snippet.push_back(lcs_pkg::CH_NL);
      else if (r < 17) snippet.push_back(lcs_pkg::CH_STAR);
      else if (r < 18) snippet.push_back(lcs_pkg::CH_SLASH);
      else snippet.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // A block comment nested d deep with filler between the markers.
  task automatic build_block(input int d);
    for (int i = 0; i < d; i++) begin
      snippet.push_back(lcs_pkg::CH_SLASH);
      snippet.push_back(lcs_pkg::CH_STAR);
      push_filler($urandom_range(0, 3));
    end
    for (int i = 0; i < d; i++) begin
      push_filler($urandom_range(0, 3));
      snippet.push_back(lcs_pkg::CH_STAR);
      snippet.push_back(lcs_pkg::CH_SLASH);
    end
  endtask

  // Sends the built text, with the odd empty item mixed in.
  task automatic send_snippet();
    foreach (snippet[i]) begin
      if ($urandom_range(0, 49) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(snippet[i], 1'b1, 1'b0);
    end
    snippet.delete();
  endtask

  // Random text made mostly of well-formed pieces, with noise and stray ends.
  task automatic random_phase(input int n);
    int stop_at;
    int r;
    logic paused;
    stop_at = items_sent + n;
    paused  = 1'b0;
    build_block(MAX_NEST + 2);
    send_snippet();
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 9) == 0) sink_calm = ~sink_calm;
      if (!paused && items_sent > stop_at - n / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        repeat ($urandom_range(1, 6)) snippet.push_back(8'($urandom_range(0, 255)));
      end else if (r < 32) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: snippet.push_back(lcs_pkg::CH_SPACE);
            1: snippet.push_back(lcs_pkg::CH_TAB);
            default: snippet.push_back(lcs_pkg::CH_NL);
          endcase
        end
      end else if (r < 47) begin
        snippet.push_back(lcs_pkg::CH_SLASH);
        snippet.push_back(lcs_pkg::CH_SLASH);
        push_filler($urandom_range(0, 6));
        snippet.push_back(lcs_pkg::CH_NL);
      end else if (r < 75) begin
        build_block(($urandom_range(0, 9) == 0) ? $urandom_range(MAX_NEST - 1, MAX_NEST + 3)
                                                 : $urandom_range(1, 3));
      end else if (r < 88) begin
        snippet.push_back(lcs_pkg::CH_SLASH);
        snippet.push_back(8'($urandom_range(0, 255)));
      end
      send_snippet();
      if (r >= 88) begin
        if ($urandom_range(0, 3) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        else send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed text under the reset settings.
    calm = 1'b1;
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text(" \t", 1'b0);
    send_text("/q", 1'b0);                      // released slash then a kept byte
    send_text("//z\n", 1'b0);                   // line comment
    send_text("/*/**/*/*", 1'b0);               // nested pair, then a kept star
    send_text("/", 1'b1);                       // held slash flushed by the end
    send_item(8'h5A, 1'b0, 1'b1);               // end with nothing to report
    send_text("/*", 1'b1);                      // text ends inside a block comment
    send_item(8'hA5, 1'b0, 1'b0);               // empty item, no result
    send_text("//", 1'b1);                      // line comment ends silently
    calm = 1'b0;
    wait_idle();

    // Random text under each register setting, the extremes included.
    write_reg(lcs_pkg::REG_LINE_COMMENTS, 1'b0);
    write_reg(lcs_pkg::REG_NESTING, 1'b0);
    random_phase(250);
    wait_idle();
    write_reg(lcs_pkg::REG_LINE_COMMENTS, 1'b1);
    random_phase(250);
    wait_idle();
    write_reg(lcs_pkg::REG_LINE_COMMENTS, 1'b0);
    write_reg(lcs_pkg::REG_NESTING, 1'b1);
    random_phase(250);
    wait_idle();
    write_reg(lcs_pkg::REG_LINE_COMMENTS, 1'b1);
    random_phase(250);

    // Drain and settle before the verdict.
    in_valid  <= 1'b0;
    sink_calm = 1'b1;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Covered %0d text items and %0d results over all four comment settings,",
             items_sent, checked);
    $display("including saturated nesting, held slashes and every kind of text end.");
    if (mismatches == 0 && pending == 0) begin
      $display("layout_and_comment_skipper_tb OK");
    end else begin
      $display("layout_and_comment_skipper_tb NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("layout_and_comment_skipper_tb NOT OK");
    $finish;
  end

endmodule
